// ----- rtl/m3inv_pkg.sv -----
// Shared widths, types and the division step for the 3x3 inverse core.
`default_nettype none
package m3inv_pkg;

    localparam int NLANE = 9;                 // matrix elements, row-major
    localparam int EW    = 16;                // Q8.8 element
    localparam int OW    = 32;                // Q16.16 result
    localparam int TW    = 16;                // tolerance register
    localparam int PW    = 2 * EW;            // 2x2 cofactor product
    localparam int AW    = PW + 1;            // cofactor difference
    localparam int MW    = AW - 1;            // cofactor magnitude
    localparam int XW    = EW + AW;           // determinant term
    localparam int DW    = XW + 2;            // determinant sum of three terms
    localparam int RW    = DW - 1;            // determinant magnitude, remainder
    localparam int FRAC  = 24;                // dividend shift
    localparam int QW    = OW + 1;            // quotient bits kept
    localparam int NDIV  = QW;                // one quotient bit per stage
    localparam int HW    = MW + FRAC - QW;    // dividend bits above the quotient

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [OW-1:0] res_t;
    typedef logic        [TW-1:0] tol_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [AW-1:0] adj_t;
    typedef logic        [MW-1:0] mag_t;
    typedef logic signed [XW-1:0] term_t;
    typedef logic signed [DW-1:0] det_t;
    typedef logic        [RW-1:0] rem_t;
    typedef logic        [QW-1:0] quo_t;

    localparam res_t POS_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam res_t NEG_MIN = {1'b1, {(OW-1){1'b0}}};

    typedef struct packed {
        elem_t [NLANE-1:0] e;
        mag_t  [NLANE-1:0] mc;
        logic  [NLANE-1:0] neg;
        logic  [NLANE-1:0] ovf;
        rem_t  [NLANE-1:0] r;
        quo_t  [NLANE-1:0] q;
        rem_t              dmag;
        logic              sing;
    } div_t;

    // One restoring step: shift in a dividend bit, subtract if it fits.
    function automatic logic [RW:0] div_step(rem_t r, rem_t d, logic b);
        logic [RW:0] t;
        logic [RW:0] s;
        t = {r, b};
        s = t - {1'b0, d};
        if (t >= {1'b0, d})
            div_step = {s[RW-1:0], 1'b1};
        else
            div_step = {t[RW-1:0], 1'b0};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/m3inv_if.sv -----
// Stream and configuration interfaces of the 3x3 inverse core.
`default_nettype none
interface m3inv_in_if;
    import m3inv_pkg::*;
    logic  valid;
    logic  ready;
    elem_t in_r0c0, in_r0c1, in_r0c2;
    elem_t in_r1c0, in_r1c1, in_r1c2;
    elem_t in_r2c0, in_r2c1, in_r2c2;
    modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                    in_r2c0, in_r2c1, in_r2c2, input ready);
    modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                    in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3inv_out_if;
    import m3inv_pkg::*;
    logic valid;
    logic ready;
    res_t out_r0c0, out_r0c1, out_r0c2;
    res_t out_r1c0, out_r1c1, out_r1c2;
    res_t out_r2c0, out_r2c1, out_r2c2;
    logic singular;
    modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                    out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, input ready);
    modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                    out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, output ready);
endinterface

interface m3inv_cfg_if;
    import m3inv_pkg::*;
    logic valid;
    logic ready;
    tol_t data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/matrix3x3_inverse_core.sv -----
// Top level: pipelined 3x3 fixed-point matrix inverse by the adjugate.
`default_nettype none
//  channel   dir  word
//  cfg       in   det_tolerance, 16 bit unsigned
//  mat_in    in   nine Q8.8 elements, row-major
//  mat_out   out  nine Q16.16 elements plus singular flag
//
//  One word enters and one leaves every cycle unless mat_out stalls.
//  The depth is set by the quotient: a 33-stage restoring divider,
//  one quotient bit per stage, nine lanes side by side, after six
//  stages of products, cofactors, determinant and magnitudes.
//  Each stage loads when it is empty or the stage after it moves, so
//  a stall fills bubbles first and loses or repeats no word.
//  Reset clears the valid bits and the tolerance register only.
module matrix3x3_inverse_core (
    input  wire logic clk,
    input  wire logic rst_n,
    m3inv_cfg_if.sink   cfg,
    m3inv_in_if.sink    mat_in,
    m3inv_out_if.source mat_out
);
    import m3inv_pkg::*;

    localparam int NSTG = 6 + NDIV + 1;   // front stages, divider, output
    localparam int SDIV = 5;              // stage of the divider seed

    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   en;
    tol_t            tol_reg;

    elem_t e0_reg [NLANE];
    elem_t e1_reg [NLANE];
    prod_t p1_reg [2*NLANE];
    elem_t e2_reg [NLANE];
    adj_t  a2_reg [NLANE];
    elem_t e3_reg [NLANE];
    adj_t  a3_reg [NLANE];
    term_t t3_reg [3];
    elem_t e4_reg [NLANE];
    adj_t  a4_reg [NLANE];
    det_t  det4_reg;
    div_t  dv_reg [NDIV+1];
    div_t  dv_next [NDIV+1];
    res_t  o_reg  [NLANE];
    logic  sing_reg;

    // Tolerance register; always ready.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg.valid)
            tol_reg <= cfg.data;
    end

    // Stage enables: load when empty or when the next stage moves.
    always_comb
    begin
        en[NSTG] = mat_out.ready;
        for (int k = NSTG - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end
    assign mat_in.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= mat_in.valid;
            for (int k = 1; k < NSTG; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Seed of the divider: magnitudes, signs, singular test, overflow.
    always_comb
    begin
        logic  dneg;
        det_t  dabs;
        adj_t  aabs;
        dneg = det4_reg[DW-1];
        dabs = dneg ? -det4_reg : det4_reg;
        dv_next[0].e    = '0;
        dv_next[0].dmag = dabs[RW-1:0];
        dv_next[0].sing = dv_next[0].dmag <= RW'(tol_reg);
        for (int i = 0; i < NLANE; i++)
        begin
            aabs = a4_reg[i][AW-1] ? -a4_reg[i] : a4_reg[i];
            dv_next[0].e[i]   = e4_reg[i];
            dv_next[0].mc[i]  = aabs[MW-1:0];
            dv_next[0].neg[i] = a4_reg[i][AW-1] ^ dneg;
            dv_next[0].r[i]   = RW'(dv_next[0].mc[i][MW-1:MW-HW]);
            dv_next[0].ovf[i] = dv_next[0].r[i] >= dv_next[0].dmag;
            dv_next[0].q[i]   = '0;
        end
        // One quotient bit per stage, most significant first.
        for (int j = 1; j <= NDIV; j++)
        begin
            dv_next[j] = dv_reg[j-1];
            for (int i = 0; i < NLANE; i++)
            begin
                logic        b;
                logic [RW:0] st;
                b  = (NDIV - j >= FRAC) ? dv_reg[j-1].mc[i][(NDIV - j - FRAC) % MW] : 1'b0;
                st = div_step(dv_reg[j-1].r[i], dv_reg[j-1].dmag, b);
                dv_next[j].r[i] = st[RW:1];
                dv_next[j].q[i] = {dv_reg[j-1].q[i][QW-2:0], st[0]};
            end
        end
    end

    // Payload registers; no reset.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e0_reg[0] <= mat_in.in_r0c0; e0_reg[1] <= mat_in.in_r0c1;
            e0_reg[2] <= mat_in.in_r0c2; e0_reg[3] <= mat_in.in_r1c0;
            e0_reg[4] <= mat_in.in_r1c1; e0_reg[5] <= mat_in.in_r1c2;
            e0_reg[6] <= mat_in.in_r2c0; e0_reg[7] <= mat_in.in_r2c1;
            e0_reg[8] <= mat_in.in_r2c2;
        end
        // Cofactor products.
        if (en[1])
        begin
            e1_reg     <= e0_reg;
            p1_reg[0]  <= PW'(e0_reg[4]) * PW'(e0_reg[8]);
            p1_reg[1]  <= PW'(e0_reg[7]) * PW'(e0_reg[5]);
            p1_reg[2]  <= PW'(e0_reg[7]) * PW'(e0_reg[2]);
            p1_reg[3]  <= PW'(e0_reg[1]) * PW'(e0_reg[8]);
            p1_reg[4]  <= PW'(e0_reg[1]) * PW'(e0_reg[5]);
            p1_reg[5]  <= PW'(e0_reg[4]) * PW'(e0_reg[2]);
            p1_reg[6]  <= PW'(e0_reg[6]) * PW'(e0_reg[5]);
            p1_reg[7]  <= PW'(e0_reg[3]) * PW'(e0_reg[8]);
            p1_reg[8]  <= PW'(e0_reg[0]) * PW'(e0_reg[8]);
            p1_reg[9]  <= PW'(e0_reg[6]) * PW'(e0_reg[2]);
            p1_reg[10] <= PW'(e0_reg[3]) * PW'(e0_reg[2]);
            p1_reg[11] <= PW'(e0_reg[0]) * PW'(e0_reg[5]);
            p1_reg[12] <= PW'(e0_reg[3]) * PW'(e0_reg[7]);
            p1_reg[13] <= PW'(e0_reg[6]) * PW'(e0_reg[4]);
            p1_reg[14] <= PW'(e0_reg[6]) * PW'(e0_reg[1]);
            p1_reg[15] <= PW'(e0_reg[0]) * PW'(e0_reg[7]);
            p1_reg[16] <= PW'(e0_reg[0]) * PW'(e0_reg[4]);
            p1_reg[17] <= PW'(e0_reg[3]) * PW'(e0_reg[1]);
        end
        // Signed adjugate; the sign of odd entries is folded into the pairing.
        if (en[2])
        begin
            e2_reg <= e1_reg;
            for (int i = 0; i < NLANE; i++)
                a2_reg[i] <= AW'(p1_reg[2*i]) - AW'(p1_reg[2*i+1]);
        end
        // Determinant terms along the first row.
        if (en[3])
        begin
            e3_reg    <= e2_reg;
            a3_reg    <= a2_reg;
            t3_reg[0] <= XW'(e2_reg[0]) * XW'(a2_reg[0]);
            t3_reg[1] <= XW'(e2_reg[1]) * XW'(a2_reg[3]);
            t3_reg[2] <= XW'(e2_reg[2]) * XW'(a2_reg[6]);
        end
        if (en[4])
        begin
            e4_reg   <= e3_reg;
            a4_reg   <= a3_reg;
            det4_reg <= DW'(t3_reg[0]) + DW'(t3_reg[1]) + DW'(t3_reg[2]);
        end
        for (int j = 0; j <= NDIV; j++)
            if (en[SDIV+j])
                dv_reg[j] <= dv_next[j];
        // Saturate the quotient, or echo the input widened to Q16.16.
        if (en[NSTG-1])
        begin
            sing_reg <= dv_reg[NDIV].sing;
            for (int i = 0; i < NLANE; i++)
            begin
                if (dv_reg[NDIV].sing)
                    o_reg[i] <= {{(OW-EW-8){dv_reg[NDIV].e[i][EW-1]}}, dv_reg[NDIV].e[i], 8'b0};
                else if (!dv_reg[NDIV].neg[i])
                    o_reg[i] <= (dv_reg[NDIV].ovf[i] || dv_reg[NDIV].q[i] > QW'(POS_MAX))
                                ? POS_MAX : res_t'(dv_reg[NDIV].q[i][OW-1:0]);
                else
                    o_reg[i] <= (dv_reg[NDIV].ovf[i] || dv_reg[NDIV].q[i] > {1'b0, NEG_MIN})
                                ? NEG_MIN : -res_t'(dv_reg[NDIV].q[i][OW-1:0]);
            end
        end
    end

    assign mat_out.valid    = v_reg[NSTG-1];
    assign mat_out.singular = sing_reg;
    assign mat_out.out_r0c0 = o_reg[0];
    assign mat_out.out_r0c1 = o_reg[1];
    assign mat_out.out_r0c2 = o_reg[2];
    assign mat_out.out_r1c0 = o_reg[3];
    assign mat_out.out_r1c1 = o_reg[4];
    assign mat_out.out_r1c2 = o_reg[5];
    assign mat_out.out_r2c0 = o_reg[6];
    assign mat_out.out_r2c1 = o_reg[7];
    assign mat_out.out_r2c2 = o_reg[8];

endmodule
`default_nettype wire

// ----- tb/sv/tb_matrix3x3_inverse_core.sv -----
// Testbench for the pipelined 3x3 fixed-point matrix inverse core.
`timescale 1ns / 100ps
`default_nettype none
module tb_matrix3x3_inverse_core;
    import m3inv_pkg::*;

    // Idle profiles: percent of cycles the sender idles / the receiver stalls
    typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        res_t el [9];
        logic sing;
    } inverse_t;

    logic clk;
    logic rst_n;

    m3inv_cfg_if cfg ();
    m3inv_in_if  mat_in ();
    m3inv_out_if mat_out ();

    matrix3x3_inverse_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg.sink),
        .mat_in  (mat_in.sink),
        .mat_out (mat_out.source)
    );

    // Shadow of the tolerance register and the queue of predicted inverses
    tol_t     tolerance;
    inverse_t pending_inverses [$];
    int       error_count;
    int       src_idle_pct;
    int       snk_stall_pct;
    int       hold_off_cycles;
    longint   cycle_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_matrix3x3_inverse_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: adjugate over determinant, truncate toward zero, saturate
    // ------------------------------------------------------------------
    function automatic res_t divide_q16(longint cof, longint det);
        logic   neg;
        longint unsigned mc;
        longint unsigned md;
        longint unsigned q;
        neg = (cof < 0) != (det < 0);
        mc  = (cof < 0) ? -cof : cof;
        md  = (det < 0) ? -det : det;
        q   = (mc << 24) / md;
        if (!neg)
        begin
            if (q > 64'h7FFF_FFFF)
                q = 64'h7FFF_FFFF;
            return res_t'(q);
        end
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return res_t'(-q);
    endfunction

    function automatic inverse_t invert_matrix(elem_t m [9], tol_t tol);
        inverse_t r;
        longint   e [9];
        longint   adj [9];
        longint   det;
        longint   mag;
        for (int i = 0; i < 9; i++)
            e[i] = m[i];
        adj[0] =   e[4] * e[8] - e[7] * e[5];
        adj[1] = -(e[1] * e[8] - e[7] * e[2]);
        adj[2] =   e[1] * e[5] - e[4] * e[2];
        adj[3] = -(e[3] * e[8] - e[6] * e[5]);
        adj[4] =   e[0] * e[8] - e[6] * e[2];
        adj[5] = -(e[0] * e[5] - e[3] * e[2]);
        adj[6] =   e[3] * e[7] - e[6] * e[4];
        adj[7] = -(e[0] * e[7] - e[6] * e[1]);
        adj[8] =   e[0] * e[4] - e[3] * e[1];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        mag = (det < 0) ? -det : det;
        // Singular: echo the input widened to Q16.16
        r.sing = (mag <= longint'(tol));
        for (int i = 0; i < 9; i++)
            r.el[i] = r.sing ? res_t'(e[i] * 256) : divide_q16(adj[i], det);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, a long hold-off on request, word checking
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_out.ready   <= 1'b0;
            hold_off_cycles <= 0;
        end
        else
        begin
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                mat_out.ready   <= 1'b0;
            end
            else
                mat_out.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && mat_out.valid && mat_out.ready)
        begin
            res_t     got [9];
            inverse_t want;
            got = '{mat_out.out_r0c0, mat_out.out_r0c1, mat_out.out_r0c2,
                    mat_out.out_r1c0, mat_out.out_r1c1, mat_out.out_r1c2,
                    mat_out.out_r2c0, mat_out.out_r2c1, mat_out.out_r2c2};
            if (pending_inverses.size() == 0)
            begin
                error_count++;
                $display("unexpected output word");
            end
            else
            begin
                want = pending_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.el[i])
                        report_mismatch($sformatf("out_r%0dc%0d", i / 3, i % 3),
                                        got[i], want.el[i]);
                if (mat_out.singular !== want.sing)
                    report_mismatch("singular", mat_out.singular, want.sing);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one matrix, hold until accepted, predict at acceptance.
    // Valid stays high on return; an idle cycle or the drain drops it.
    task automatic send_matrix(elem_t m [9]);
        while ($urandom_range(99) < src_idle_pct)
        begin
            mat_in.valid <= 1'b0;
            @(posedge clk);
        end
        mat_in.valid   <= 1'b1;
        mat_in.in_r0c0 <= m[0];
        mat_in.in_r0c1 <= m[1];
        mat_in.in_r0c2 <= m[2];
        mat_in.in_r1c0 <= m[3];
        mat_in.in_r1c1 <= m[4];
        mat_in.in_r1c2 <= m[5];
        mat_in.in_r2c0 <= m[6];
        mat_in.in_r2c1 <= m[7];
        mat_in.in_r2c2 <= m[8];
        do
            @(posedge clk);
        while (!mat_in.ready);
        pending_inverses.push_back(invert_matrix(m, tolerance));
    endtask

    task automatic drain_results();
        mat_in.valid <= 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    task automatic write_tolerance(tol_t value);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        tolerance = value;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pace(pace_t p);
        case (p)
            PACE_FULL:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            PACE_SRC_IDLE:  begin src_idle_pct = 85; snk_stall_pct = 0;  end
            PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 85; end
            default:        begin src_idle_pct = 28; snk_stall_pct = 28; end
        endcase
    endtask

    // Random element: mostly small values so that quotients stay in range
    function automatic elem_t random_elem();
        case ($urandom_range(9))
            0:       return elem_t'($urandom);
            1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            2:       return 16'sh0000;
            default: return elem_t'($signed($urandom_range(2048)) - 1024);
        endcase
    endfunction

    function automatic void random_matrix(output elem_t m [9]);
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++)
            m[i] = random_elem();
        // Force near-singular shapes: repeated row or repeated column
        if (kind == 0)
            for (int c = 0; c < 3; c++)
                m[3 + c] = m[c];
        else if (kind == 1)
            for (int r = 0; r < 3; r++)
                m[3 * r + 2] = m[3 * r];
        else if (kind == 2)
        begin
            // Signed identity diag(1, -1, 1) plus small noise: well conditioned
            for (int i = 0; i < 9; i++)
                m[i] = elem_t'($signed($urandom_range(15)) - 8);
            m[0] = m[0] + 16'sh0100;
            m[4] = m[4] - 16'sh0100;
            m[8] = m[8] + 16'sh0100;
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        elem_t m [9];
        set_pace(PACE_FULL);
        m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};  // identity
        send_matrix(m);
        m = '{16'sh0200, 0, 0, 0, 16'shFF00, 0, 0, 0, 16'sh0080};
        send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                          // zero determinant
        send_matrix(m);
        m = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7FFF, 16'sh8000, 16'sh7FFF};                     // singular echo of extremes
        send_matrix(m);
        m = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};  // tiny: inverse diagonal 256.0
        send_matrix(m);
        m = '{16'shFFFF, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};  // inverse diagonal -256.0, 256.0, 256.0
        send_matrix(m);
        m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};  // most negative diagonal
        send_matrix(m);
        m = '{16'sh7FFF, 16'sh8000, 0, 16'sh8000, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        send_matrix(m);
        m = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0};  // permutation
        send_matrix(m);
        m = '{16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh1234, 16'shEDCB, 16'sh0F0F,
              16'shF0F0, 16'sh3C3C, 16'shC3C3};
        send_matrix(m);
        drain_results();
    endtask

    task automatic test_tolerance();
        elem_t m [9];
        // det = 1 LSB sits at the boundary of tolerance 0 and 1
        m = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};
        write_tolerance(16'd1);
        send_matrix(m);
        m = '{16'sh0002, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};  // det 2, just above
        send_matrix(m);
        write_tolerance(16'hFFFF);
        m = '{16'sh0100, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'shFF01};  // det -65280
        send_matrix(m);
        m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0001};  // det 65536
        send_matrix(m);
        drain_results();
    endtask

    task automatic test_random_phase(pace_t p, tol_t tol, int count);
        elem_t m [9];
        write_tolerance(tol);
        set_pace(p);
        for (int n = 0; n < count; n++)
        begin
            random_matrix(m);
            send_matrix(m);
        end
    endtask

    // Hold the receiver off long enough for the pipeline to back up
    task automatic test_backpressure();
        elem_t m [9];
        set_pace(PACE_FULL);
        hold_off_cycles = 150;
        for (int n = 0; n < 100; n++)
        begin
            random_matrix(m);
            send_matrix(m);
        end
        // Pause the sender until every result has arrived
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cycle_count  = 0;
        error_count  = 0;
        tolerance    = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        mat_in.valid = 1'b0;
        {mat_in.in_r0c0, mat_in.in_r0c1, mat_in.in_r0c2} = '0;
        {mat_in.in_r1c0, mat_in.in_r1c1, mat_in.in_r1c2} = '0;
        {mat_in.in_r2c0, mat_in.in_r2c1, mat_in.in_r2c2} = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_tolerance();
        test_random_phase(PACE_FULL,      16'd0,     400);
        test_random_phase(PACE_SRC_IDLE,  16'd300,   300);
        test_random_phase(PACE_SNK_STALL, 16'hFFFF,  300);
        test_random_phase(PACE_BOTH,      16'd1,     300);
        test_backpressure();
        test_random_phase(PACE_BOTH,      16'h8000,  230);
        drain_results();

        if (error_count == 0)
            $display("tb_matrix3x3_inverse_core: clean");
        else
            $display("tb_matrix3x3_inverse_core: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/m3inv_pkg.sv
rtl/m3inv_if.sv
rtl/matrix3x3_inverse_core.sv
tb/sv/tb_matrix3x3_inverse_core.sv
